[rtl/irnr_pkg.sv]
package irnr_pkg;

  // Frame store geometry
  localparam int MAX_SRC_WIDTH  = 640;
  localparam int MAX_SRC_HEIGHT = 480;
  localparam int MAX_DST_DIM    = 1024;
  localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * 3 / 2;
  localparam int ADDR_W         = 19;

  // Field widths
  localparam int SW_W  = 10;
  localparam int SH_W  = 9;
  localparam int DIM_W = 11;
  localparam int CNT_W = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Coordinate divider: 20 dividend bits, one bit per cycle
  localparam int DIV_BITS = 20;
  localparam int DIV_CNT_W = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

  // Store read select
  localparam logic [1:0] RD_Y  = 2'd0;
  localparam logic [1:0] RD_CB = 2'd1;
  localparam logic [1:0] RD_CR = 2'd2;

  // Q16 BT.601 coefficients
  localparam logic signed [17:0] K_R_CR = 18'sd91881;
  localparam logic signed [17:0] K_G_CB = 18'sd22553;
  localparam logic signed [17:0] K_G_CR = 18'sd46802;
  localparam logic signed [17:0] K_B_CB = 18'sd116130;

  // Controller to datapath commands
  typedef struct packed {
    logic       mem_wr;
    logic       mul_en;
    logic       div_init;
    logic       div_step;
    logic       adr_en;
    logic [1:0] rd_sel;
    logic       cap_y;
    logic       cap_cb;
    logic       cap_cr;
    logic       prod_en;
    logic       out_load;
  } irnr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } irnr_sts_t;

  // Q16 sum to byte: truncate toward zero, clamp to 0..255
  function automatic logic [7:0] to_byte(input logic signed [27:0] s);
    logic [7:0] v;
    if (s[27]) begin
      v = 8'd0;
    end else if (|s[26:24]) begin
      v = 8'd255;
    end else begin
      v = s[23:16];
    end
    return v;
  endfunction

endpackage

[rtl/irnr_ctrl.sv]
module irnr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_req_type,
  output logic                 in_ready,
  input  irnr_pkg::irnr_sts_t  sts,
  output irnr_pkg::irnr_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DIVI = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_ADR  = 4'd4;
  localparam logic [3:0] S_RDY  = 4'd5;
  localparam logic [3:0] S_RDB  = 4'd6;
  localparam logic [3:0] S_RDR  = 4'd7;
  localparam logic [3:0] S_CAPR = 4'd8;
  localparam logic [3:0] S_PROD = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [irnr_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.rd_sel = irnr_pkg::RD_Y;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type) state_nxt = S_MUL;
          else cmd.mem_wr = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == irnr_pkg::DIV_CNT_W'(irnr_pkg::DIV_BITS - 1)) state_nxt = S_ADR;
      end
      S_ADR: begin
        cmd.adr_en = 1'b1;
        state_nxt = S_RDY;
      end
      S_RDY: begin
        cmd.rd_sel = irnr_pkg::RD_Y;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.rd_sel = irnr_pkg::RD_CB;
        cmd.cap_y = 1'b1;
        state_nxt = S_RDR;
      end
      S_RDR: begin
        cmd.rd_sel = irnr_pkg::RD_CR;
        cmd.cap_cb = 1'b1;
        state_nxt = S_CAPR;
      end
      S_CAPR: begin
        cmd.cap_cr = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod_en = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for a free output register
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[rtl/irnr_dp.sv]
module irnr_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  irnr_pkg::irnr_cmd_t                   cmd,
  output irnr_pkg::irnr_sts_t                   sts,
  input  logic [irnr_pkg::ADDR_W-1:0]           in_frame_addr,
  input  logic [7:0]                            in_byte_value,
  input  logic                                  cfg_valid,
  input  logic [irnr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [irnr_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            out_red,
  output logic [7:0]                            out_green,
  output logic [7:0]                            out_blue,
  output logic [7:0]                            out_alpha,
  output logic                                  out_frame_last
);

  localparam int AW = irnr_pkg::ADDR_W;
  localparam int DB = irnr_pkg::DIV_BITS;

  // Frame store
  logic [7:0] mem [0:irnr_pkg::STORE_DEPTH-1];
  logic [7:0] rd_q_r;
  logic [AW-1:0] rd_addr;

  // Configuration and counters
  logic [irnr_pkg::SW_W-1:0]  sw_r;
  logic [irnr_pkg::SH_W-1:0]  sh_r;
  logic [irnr_pkg::DIM_W-1:0] dw_r, dh_r;
  logic [irnr_pkg::CNT_W-1:0] col_r, row_r;
  logic [irnr_pkg::SW_W-1:0]  sw_nxt;
  logic [irnr_pkg::SH_W-1:0]  sh_nxt;
  logic [irnr_pkg::DIM_W-1:0] dw_nxt, dh_nxt;

  // Address path
  logic [DB-1:0] px_r, py_r;
  logic [AW-1:0] plane_r;
  logic [DB-1:0] qx_r, qy_r;
  logic [irnr_pkg::DIM_W:0] rx_r, ry_r;
  logic [irnr_pkg::DIM_W:0] rx_sh, ry_sh;
  logic [AW-1:0] y_addr_r, cb_addr_r, cr_addr_r;
  logic [AW-1:0] cidx;

  // Color path
  logic [7:0] y_r, cb_r, cr_r;
  logic signed [9:0] dcb, dcr;
  logic signed [27:0] pr_r, pg1_r, pg2_r, pb_r;
  logic signed [27:0] ybase;
  logic [irnr_pkg::DIM_W-1:0] col_inc, row_inc;
  logic col_end, row_end;
  logic out_valid_r;

  // Store write and registered read
  always_comb begin
    case (cmd.rd_sel)
      irnr_pkg::RD_Y:  rd_addr = y_addr_r;
      irnr_pkg::RD_CB: rd_addr = cb_addr_r;
      irnr_pkg::RD_CR: rd_addr = cr_addr_r;
      default:         rd_addr = y_addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && (in_frame_addr < AW'(irnr_pkg::STORE_DEPTH))) begin
      mem[in_frame_addr] <= in_byte_value;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Register saturation
  always_comb begin
    sw_nxt = cfg_data[irnr_pkg::SW_W-1:0];
    if (sw_nxt < 10'd2) sw_nxt = 10'd2;
    else if (sw_nxt > 10'(irnr_pkg::MAX_SRC_WIDTH)) sw_nxt = 10'(irnr_pkg::MAX_SRC_WIDTH);
    sh_nxt = cfg_data[irnr_pkg::SH_W-1:0];
    if (sh_nxt < 9'd2) sh_nxt = 9'd2;
    else if (sh_nxt > 9'(irnr_pkg::MAX_SRC_HEIGHT)) sh_nxt = 9'(irnr_pkg::MAX_SRC_HEIGHT);
    dw_nxt = cfg_data;
    if (dw_nxt < 11'd1) dw_nxt = 11'd1;
    else if (dw_nxt > 11'(irnr_pkg::MAX_DST_DIM)) dw_nxt = 11'(irnr_pkg::MAX_DST_DIM);
    dh_nxt = dw_nxt;
  end

  // Raster counters
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign col_end = (col_inc >= dw_r);
  assign row_end = (row_inc >= dh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r  <= 10'(irnr_pkg::MAX_SRC_WIDTH);
      sh_r  <= 9'(irnr_pkg::MAX_SRC_HEIGHT);
      dw_r  <= 11'd640;
      dh_r  <= 11'd480;
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        irnr_pkg::REG_SRC_WIDTH:  sw_r <= sw_nxt;
        irnr_pkg::REG_SRC_HEIGHT: sh_r <= sh_nxt;
        irnr_pkg::REG_DST_WIDTH:  dw_r <= dw_nxt;
        irnr_pkg::REG_DST_HEIGHT: dh_r <= dh_nxt;
        default: ;
      endcase
      if (cfg_index <= irnr_pkg::REG_DST_HEIGHT) begin
        col_r <= '0;
        row_r <= '0;
      end
    end else if (cmd.out_load) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_inc[irnr_pkg::CNT_W-1:0];
      end else begin
        col_r <= col_inc[irnr_pkg::CNT_W-1:0];
      end
    end
  end

  // Scaled coordinates: products, then restoring division one bit a cycle
  assign rx_sh = {rx_r[irnr_pkg::DIM_W-1:0], qx_r[DB-1]};
  assign ry_sh = {ry_r[irnr_pkg::DIM_W-1:0], qy_r[DB-1]};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      px_r    <= DB'(col_r * sw_r);
      py_r    <= DB'(row_r * sh_r);
      plane_r <= AW'(sw_r * sh_r);
    end
    if (cmd.div_init) begin
      qx_r <= px_r;
      qy_r <= py_r;
      rx_r <= '0;
      ry_r <= '0;
    end else if (cmd.div_step) begin
      if (rx_sh >= {1'b0, dw_r}) begin
        rx_r <= rx_sh - {1'b0, dw_r};
        qx_r <= {qx_r[DB-2:0], 1'b1};
      end else begin
        rx_r <= rx_sh;
        qx_r <= {qx_r[DB-2:0], 1'b0};
      end
      if (ry_sh >= {1'b0, dh_r}) begin
        ry_r <= ry_sh - {1'b0, dh_r};
        qy_r <= {qy_r[DB-2:0], 1'b1};
      end else begin
        ry_r <= ry_sh;
        qy_r <= {qy_r[DB-2:0], 1'b0};
      end
    end
  end

  // Luma and chroma addresses
  assign cidx = AW'(qy_r[irnr_pkg::SH_W-1:1] * sw_r[irnr_pkg::SW_W-1:1])
              + AW'(qx_r[irnr_pkg::SW_W-1:1]);

  always_ff @(posedge clk) begin
    if (cmd.adr_en) begin
      y_addr_r  <= AW'(qy_r[irnr_pkg::SH_W-1:0] * sw_r) + AW'(qx_r[irnr_pkg::SW_W-1:0]);
      cb_addr_r <= plane_r + cidx;
      cr_addr_r <= plane_r + (plane_r >> 2) + cidx;
    end
  end

  // Sample capture and coefficient products
  assign dcb = $signed({2'b00, cb_r}) - 10'sd128;
  assign dcr = $signed({2'b00, cr_r}) - 10'sd128;
  assign ybase = $signed({4'b0000, y_r, 16'h0000});

  always_ff @(posedge clk) begin
    if (cmd.cap_y)  y_r  <= rd_q_r;
    if (cmd.cap_cb) cb_r <= rd_q_r;
    if (cmd.cap_cr) cr_r <= rd_q_r;
    if (cmd.prod_en) begin
      pr_r  <= 28'(irnr_pkg::K_R_CR * dcr);
      pg1_r <= 28'(irnr_pkg::K_G_CB * dcb);
      pg2_r <= 28'(irnr_pkg::K_G_CR * dcr);
      pb_r  <= 28'(irnr_pkg::K_B_CB * dcb);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red        <= irnr_pkg::to_byte(ybase + pr_r);
      out_green      <= irnr_pkg::to_byte(ybase - pg1_r - pg2_r);
      out_blue       <= irnr_pkg::to_byte(ybase + pb_r);
      out_frame_last <= col_end && row_end;
    end
  end

  assign out_alpha    = 8'd255;
  assign out_valid    = out_valid_r;
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

[rtl/i420_nearest_resize_to_rgba_top.sv]
// I420 nearest-neighbor resizer with full-range BT.601 conversion to RGBA.
// Input channel (in_*): a word with in_req_type 0 writes in_byte_value into
// the planar frame store at in_frame_addr (Y plane, then Cb, then Cr); loads
// past the store are dropped. A word with in_req_type 1 emits the next RGBA
// pixel of the output frame in raster order; out_frame_last marks the last.
// Configuration channel (cfg_*): index 0..3 selects source width, source
// height, output width, output height; values are saturated to their range,
// and writing any of them restarts the output frame. cfg_ready is always high.
// Sequencing: a load does not stall the input, so loads go back to back.
// An emit steps through the product, divider set-up, divide, address,
// Y, Cb and Cr read, capture, product and final states before the result
// register loads, and the next word is taken when it returns to idle. A
// restoring divider finds the source coordinates (one quotient bit per
// cycle); one store read port serves three registered reads, Y, Cb, Cr.
// The result sits in an output register, so the next word is taken while it
// waits; a second emit holds in its last step until the receiver frees it.
// Reset (rst_n low, synchronous) restores 640x480 to 640x480 and the raster
// position; the frame store is not cleared and needs no clearing pass.
module i420_nearest_resize_to_rgba_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [irnr_pkg::ADDR_W-1:0]         in_frame_addr,
  input  logic [7:0]                          in_byte_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [irnr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irnr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic [7:0]                          out_alpha,
  output logic                                out_frame_last
);

  irnr_pkg::irnr_cmd_t cmd;
  irnr_pkg::irnr_sts_t sts;

  assign cfg_ready = 1'b1;

  irnr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  irnr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_frame_addr  (in_frame_addr),
    .in_byte_value  (in_byte_value),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_frame_last (out_frame_last)
  );

  // An emit word occupies the sequencer
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type |=> !in_ready)
    else $error("input taken during emit");

  // A load does not stall the input
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_req_type |=> in_ready)
    else $error("load stalled the input");

  // A new result appears only as the sequencer returns to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded outside final step");

endmodule

[tb/i420_nearest_resize_to_rgba_top_tb.sv]
`timescale 1ns / 100ps

module i420_nearest_resize_to_rgba_top_tb;
  import irnr_pkg::*;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EMIT = 1'b1;
  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int ADDR_SPAN = 1 << ADDR_W;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } rgba_t;

  // Shadow frame store, geometry and raster position; expected pixel queue
  class rgba_scoreboard;
    byte unsigned frame[];
    bit           loaded[];
    int           src_w, src_h, dst_w, dst_h;
    int           col, row;
    rgba_t        pixels_due[$];
    int           errors;

    function new();
      frame = new[STORE_DEPTH];
      loaded = new[STORE_DEPTH];
      src_w = 640; src_h = 480; dst_w = 640; dst_h = 480;
      col = 0; row = 0; errors = 0;
    endfunction

    function int clip(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SRC_WIDTH:  src_w = clip(int'(val[SW_W-1:0]), 2, MAX_SRC_WIDTH);
        REG_SRC_HEIGHT: src_h = clip(int'(val[SH_W-1:0]), 2, MAX_SRC_HEIGHT);
        REG_DST_WIDTH:  dst_w = clip(int'(val[DIM_W-1:0]), 1, MAX_DST_DIM);
        REG_DST_HEIGHT: dst_h = clip(int'(val[DIM_W-1:0]), 1, MAX_DST_DIM);
        default: return;
      endcase
      col = 0;
      row = 0;
    endfunction

    // Store offsets of Y, Cb and Cr for the pixel at the current position
    function void pixel_addrs(output int ya, output int cba, output int cra);
      int sx, sy, plane, cidx;
      sx = int'((longint'(col) * src_w) / dst_w);
      sy = int'((longint'(row) * src_h) / dst_h);
      plane = src_w * src_h;
      cidx = (sy / 2) * (src_w / 2) + sx / 2;
      ya = sy * src_w + sx;
      cba = plane + cidx;
      cra = plane + plane / 4 + cidx;
    endfunction

    function logic [7:0] q16_to_byte(longint s);
      longint v;
      v = s / 65536;
      return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function void predict_pixel();
      int ya, cba, cra;
      longint yb, dcb, dcr;
      rgba_t p;
      pixel_addrs(ya, cba, cra);
      yb = longint'(frame[ya]) * 65536;
      dcb = longint'(frame[cba]) - 128;
      dcr = longint'(frame[cra]) - 128;
      p.red = q16_to_byte(yb + 91881 * dcr);
      p.green = q16_to_byte(yb - 22553 * dcb - 46802 * dcr);
      p.blue = q16_to_byte(yb + 116130 * dcb);
      p.alpha = 8'd255;
      p.last = (col + 1 >= dst_w) && (row + 1 >= dst_h);
      pixels_due.push_back(p);
      if (col + 1 >= dst_w) begin
        col = 0;
        row = (row + 1 >= dst_h) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void note_word(logic req, int addr, logic [7:0] val);
      if (req == REQ_EMIT) begin
        predict_pixel();
      end else if (addr < STORE_DEPTH) begin
        frame[addr] = val;
        loaded[addr] = 1'b1;
      end
    endfunction

    function void check_pixel(rgba_t got);
      rgba_t exp_p;
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel %h %h %h %h last=%b", $time,
                 got.red, got.green, got.blue, got.alpha, got.last);
        errors++;
        return;
      end
      exp_p = pixels_due.pop_front();
      if (got.red !== exp_p.red || got.green !== exp_p.green || got.blue !== exp_p.blue ||
          got.alpha !== exp_p.alpha || got.last !== exp_p.last) begin
        $display("%0t: pixel mismatch expected %h %h %h %h last=%b, actual %h %h %h %h last=%b",
                 $time, exp_p.red, exp_p.green, exp_p.blue, exp_p.alpha, exp_p.last,
                 got.red, got.green, got.blue, got.alpha, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [ADDR_W-1:0] in_frame_addr = '0;
  logic [7:0] in_byte_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic out_frame_last;

  rgba_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  i420_nearest_resize_to_rgba_top u_dut (.*);

  always #5 clk = ~clk;

  // Receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    rgba_t got;
    if (rst_n && out_valid && out_ready) begin
      got.red = out_red;
      got.green = out_green;
      got.blue = out_blue;
      got.alpha = out_alpha;
      got.last = out_frame_last;
      sb.check_pixel(got);
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_word(logic req, int addr, logic [7:0] val);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? int'($urandom_range(1, 4)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_frame_addr <= addr[ADDR_W-1:0];
    in_byte_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(req, addr, val);
  endtask

  // Emit the next pixel, first loading any store byte it reads that is unset
  task automatic emit_pixel(inout int count);
    int a[3];
    sb.pixel_addrs(a[0], a[1], a[2]);
    foreach (a[i]) begin
      if (!sb.loaded[a[i]]) begin
        send_word(REQ_LOAD, a[i], 8'($urandom_range(255)));
        count++;
      end
    end
    send_word(REQ_EMIT, int'($urandom_range(ADDR_SPAN - 1)), 8'($urandom_range(255)));
    count++;
  endtask

  // Let every expected pixel arrive and the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(int sw, int sh, int dw, int dh);
    write_cfg(REG_SRC_WIDTH, CFG_DATA_W'(sw));
    write_cfg(REG_SRC_HEIGHT, CFG_DATA_W'(sh));
    write_cfg(REG_DST_WIDTH, CFG_DATA_W'(dw));
    write_cfg(REG_DST_HEIGHT, CFG_DATA_W'(dh));
  endtask

  // Random mix: mostly pixels, some stray loads, some rewrites of live bytes
  task automatic random_phase(int n, int emit_pct);
    int count, r, a[3];
    count = 0;
    while (count < n) begin
      r = int'($urandom_range(99));
      if (r < emit_pct) begin
        emit_pixel(count);
      end else if (r < emit_pct + 12) begin
        send_word(REQ_LOAD, int'($urandom_range(ADDR_SPAN - 1)), 8'($urandom_range(255)));
        count++;
      end else begin
        sb.pixel_addrs(a[0], a[1], a[2]);
        send_word(REQ_LOAD, a[$urandom_range(2)], 8'($urandom_range(255)));
        count++;
      end
    end
  endtask

  initial begin
    int dummy, sw, sh, dw, dh;
    dummy = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: store edges, reset geometry, then clamp extremes on 2x2
    send_word(REQ_LOAD, STORE_DEPTH - 1, 8'hff);
    send_word(REQ_LOAD, STORE_DEPTH, 8'h00);
    send_word(REQ_LOAD, ADDR_SPAN - 1, 8'h55);
    emit_pixel(dummy);
    drain();
    set_geometry(2, 2, 2, 2);
    send_word(REQ_LOAD, 0, 8'h00);
    send_word(REQ_LOAD, 1, 8'hff);
    send_word(REQ_LOAD, 2, 8'h80);
    send_word(REQ_LOAD, 3, 8'hff);
    send_word(REQ_LOAD, 4, 8'h00);
    send_word(REQ_LOAD, 5, 8'hff);
    repeat (4) emit_pixel(dummy);
    send_word(REQ_LOAD, 4, 8'hff);
    send_word(REQ_LOAD, 5, 8'h00);
    repeat (5) emit_pixel(dummy);
    drain();

    // Saturation of out-of-range and masked values, and a stray index
    set_geometry(0, 0, 0, 0);
    write_cfg(REG_NONE, 11'h7ff);
    repeat (3) emit_pixel(dummy);
    drain();
    set_geometry(2047, 2047, 2047, 2047);
    send_idle_pct = 35;
    recv_idle_pct = 64;
    random_phase(60, 70);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 64;
        recv_idle_pct = 35;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(5))
        0: begin
          sw = MAX_SRC_WIDTH; sh = MAX_SRC_HEIGHT;
          dw = int'($urandom_range(1, 4)); dh = int'($urandom_range(1, 3));
        end
        1: begin
          sw = int'($urandom_range(2, 8)); sh = int'($urandom_range(2, 8));
          dw = MAX_DST_DIM; dh = int'($urandom_range(1, 2));
        end
        2: begin
          sw = int'($urandom_range(0, 2047)); sh = int'($urandom_range(0, 2047));
          dw = int'($urandom_range(0, 2047)); dh = int'($urandom_range(0, 2047));
        end
        default: begin
          sw = int'($urandom_range(2, 12)); sh = int'($urandom_range(2, 10));
          dw = int'($urandom_range(1, 12)); dh = int'($urandom_range(1, 10));
        end
      endcase
      set_geometry(sw, sh, dw, dh);
      if (ph == 9) hold_req = 1'b1;
      if ($urandom_range(3) == 0) write_cfg(REG_NONE, CFG_DATA_W'($urandom_range(2047)));
      random_phase(130, 65);
      drain();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
rtl/irnr_pkg.sv
rtl/irnr_ctrl.sv
rtl/irnr_dp.sv
rtl/i420_nearest_resize_to_rgba_top.sv
tb/i420_nearest_resize_to_rgba_top_tb.sv
